FILE: design/hlp_pkg.sv
package hlp_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_RISE_STEP   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FALL_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_PEAK  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_PEAK = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_PAUSE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PAUSE  = 3'd5;

    localparam logic [2:0] PH_RISE1  = 3'd0;
    localparam logic [2:0] PH_FALL1  = 3'd1;
    localparam logic [2:0] PH_PAUSE1 = 3'd2;
    localparam logic [2:0] PH_RISE2  = 3'd3;
    localparam logic [2:0] PH_FALL2  = 3'd4;
    localparam logic [2:0] PH_PAUSE2 = 3'd5;

    localparam logic [7:0]  RST_RISE_STEP   = 8'd15;
    localparam logic [7:0]  RST_FALL_STEP   = 8'd8;
    localparam logic [7:0]  RST_FIRST_PEAK  = 8'd255;
    localparam logic [7:0]  RST_SECOND_PEAK = 8'd180;
    localparam logic [15:0] RST_SHORT_PAUSE = 16'd120;
    localparam logic [15:0] RST_LONG_PAUSE  = 16'd800;

    typedef struct packed {
        logic [7:0]  rise_step;
        logic [7:0]  fall_step;
        logic [7:0]  first_peak;
        logic [7:0]  second_peak;
        logic [15:0] short_pause_ms;
        logic [15:0] long_pause_ms;
    } t_cfg;

endpackage

FILE: design/hlp_if.sv
interface hlp_in_if
    import hlp_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] now_ms;

    modport source (output valid, output command, output now_ms, input ready);
    modport sink (input valid, input command, input now_ms, output ready);
endinterface

interface hlp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pwm_level;
    logic       drive_update;
    logic       active;
    logic [2:0] phase_now;

    modport source (output valid, output pwm_level, output drive_update, output active,
                    output phase_now, input ready);
    modport sink (input valid, input pwm_level, input drive_update, input active,
                  input phase_now, output ready);
endinterface

interface hlp_cfg_if
    import hlp_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink (input valid, input reg_index, input data, output ready);
endinterface

FILE: design/hlp_cfg.sv
module hlp_cfg
    import hlp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    hlp_cfg_if.sink     i_cfg,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic wr_en;

    assign i_cfg.ready = 1'b1;
    assign wr_en       = i_cfg.valid;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            unique case (i_cfg.reg_index)
                REG_RISE_STEP:   n_cfg.rise_step      = i_cfg.data[7:0];
                REG_FALL_STEP:   n_cfg.fall_step      = i_cfg.data[7:0];
                REG_FIRST_PEAK:  n_cfg.first_peak     = i_cfg.data[7:0];
                REG_SECOND_PEAK: n_cfg.second_peak    = i_cfg.data[7:0];
                REG_SHORT_PAUSE: n_cfg.short_pause_ms = i_cfg.data;
                REG_LONG_PAUSE:  n_cfg.long_pause_ms  = i_cfg.data;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rise_step      <= RST_RISE_STEP;
            r_cfg.fall_step      <= RST_FALL_STEP;
            r_cfg.first_peak     <= RST_FIRST_PEAK;
            r_cfg.second_peak    <= RST_SECOND_PEAK;
            r_cfg.short_pause_ms <= RST_SHORT_PAUSE;
            r_cfg.long_pause_ms  <= RST_LONG_PAUSE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

FILE: design/hlp_core.sv
module hlp_core
    import hlp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    hlp_in_if.sink      i_in,
    hlp_out_if.source   o_out
);

    // input register
    logic        r_in_valid;
    logic [1:0]  r_cmd;
    logic [31:0] r_now;

    // pattern state
    logic        r_running;
    logic [2:0]  r_phase;
    logic [7:0]  r_level;
    logic [31:0] r_mark;

    logic        n_running;
    logic [2:0]  n_phase;
    logic [7:0]  n_level;
    logic [31:0] n_mark;
    logic        n_drive;

    // result register
    logic        r_out_valid;
    logic [7:0]  r_pwm;
    logic        r_drive;
    logic        r_active;
    logic [2:0]  r_phase_out;

    logic        advance;
    logic [31:0] elapsed;
    logic [8:0]  rise_sum;
    logic [7:0]  peak;

    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    assign elapsed  = r_now - r_mark;
    assign peak     = (r_phase == PH_RISE2) ? i_cfg.second_peak : i_cfg.first_peak;
    assign rise_sum = {1'b0, r_level} + {1'b0, i_cfg.rise_step};

    always_comb begin
        n_running = r_running;
        n_phase   = r_phase;
        n_level   = r_level;
        n_mark    = r_mark;
        n_drive   = 1'b0;
        if (r_cmd == CMD_START) begin
            n_running = 1'b1;
            n_level   = '0;
            n_phase   = PH_RISE1;
            n_mark    = r_now;
        end else if (r_cmd == CMD_STOP) begin
            n_running = 1'b0;
            n_level   = '0;
            n_phase   = PH_RISE1;
            n_drive   = 1'b1;
        end else if (r_cmd == CMD_TICK && r_running) begin
            n_drive = 1'b1;
            unique case (r_phase)
                PH_RISE1, PH_RISE2: begin
                    if (rise_sum >= {1'b0, peak}) begin
                        n_level = peak;
                        n_phase = (r_phase == PH_RISE1) ? PH_FALL1 : PH_FALL2;
                    end else begin
                        n_level = rise_sum[7:0];
                    end
                end
                PH_FALL1, PH_FALL2: begin
                    if (r_level <= i_cfg.fall_step) begin
                        n_level = '0;
                        n_phase = (r_phase == PH_FALL1) ? PH_PAUSE1 : PH_PAUSE2;
                        n_mark  = r_now;
                    end else begin
                        n_level = r_level - i_cfg.fall_step;
                    end
                end
                PH_PAUSE1: begin
                    if (elapsed >= {16'd0, i_cfg.short_pause_ms}) begin
                        n_phase = PH_RISE2;
                    end
                end
                PH_PAUSE2: begin
                    if (elapsed >= {16'd0, i_cfg.long_pause_ms}) begin
                        n_phase = PH_RISE1;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_running   <= 1'b0;
            r_phase     <= PH_RISE1;
            r_level     <= '0;
            r_mark      <= '0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_running   <= n_running;
                r_phase     <= n_phase;
                r_level     <= n_level;
                r_mark      <= n_mark;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_cmd <= i_in.command;
            r_now <= i_in.now_ms;
        end
        if (advance) begin
            r_pwm       <= n_level;
            r_drive     <= n_drive;
            r_active    <= n_running;
            r_phase_out <= n_phase;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.pwm_level    = r_pwm;
    assign o_out.drive_update = r_drive;
    assign o_out.active       = r_active;
    assign o_out.phase_now    = r_phase_out;

endmodule

FILE: design/heartbeat_led_pattern.sv
// channel  dir  payload                                          transaction
// i_in     in   command[1:0], now_ms[31:0]                       valid & ready
// o_out    out  pwm_level[7:0], drive_update, active, phase[2:0] valid & ready
// i_cfg    in   reg_index[2:0], data[15:0]                       valid & ready, ready tied 1
//
// one result per input, through the input register and then the result register
// one item per cycle while o_out.ready is high; state update and result load share one edge
// i_rst_n is synchronous: clears pattern state, valids and loads default registers
// an output stall backs up into the input register, then drops i_in.ready
module heartbeat_led_pattern
    import hlp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    hlp_cfg_if.sink     i_cfg,
    hlp_in_if.sink      i_in,
    hlp_out_if.source   o_out
);

    t_cfg cfg;

    hlp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    hlp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule

FILE: design/hlp_checker.sv
module hlp_checker
    import hlp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_pwm_level,
    input  logic       i_drive_update,
    input  logic       i_active,
    input  logic [2:0] i_phase_now
);

    // results come out of a cleared pipeline after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // a stalled result holds its contents
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pwm_level)
            && $stable(i_drive_update) && $stable(i_active) && $stable(i_phase_now))
        else $error("stalled result changed");

    // a stopped pattern sits at zero level in the first phase
    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_active |-> i_pwm_level == 8'd0 && i_phase_now == PH_RISE1)
        else $error("stopped pattern shows level or phase");

    // only the six pattern phases are ever reported
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_phase_now <= PH_PAUSE2)
        else $error("phase out of range");

endmodule

bind heartbeat_led_pattern hlp_checker u_hlp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_pwm_level    (o_out.pwm_level),
    .i_drive_update (o_out.drive_update),
    .i_active       (o_out.active),
    .i_phase_now    (o_out.phase_now)
);

FILE: verif/tb_heartbeat_led_pattern.sv
module tb_heartbeat_led_pattern;
    import hlp_pkg::*;

    localparam logic [1:0]           CMD_IGNORED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;

    typedef struct packed {
        logic [7:0] pwm_level;
        logic       drive_update;
        logic       active;
        logic [2:0] phase_now;
    } t_led_result;

    class led_pattern_tracker;
        t_cfg        regs;
        logic        running;
        logic [2:0]  phase;
        logic [7:0]  level;
        logic [31:0] mark_ms;
        t_led_result pending[$];
        int          errors = 0;

        function void restore_defaults();
            regs = '{rise_step: RST_RISE_STEP, fall_step: RST_FALL_STEP,
                     first_peak: RST_FIRST_PEAK, second_peak: RST_SECOND_PEAK,
                     short_pause_ms: RST_SHORT_PAUSE, long_pause_ms: RST_LONG_PAUSE};
            running = 1'b0;
            phase   = PH_RISE1;
            level   = '0;
            mark_ms = '0;
        endfunction

        function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_RISE_STEP:   regs.rise_step      = value[7:0];
                REG_FALL_STEP:   regs.fall_step      = value[7:0];
                REG_FIRST_PEAK:  regs.first_peak     = value[7:0];
                REG_SECOND_PEAK: regs.second_peak    = value[7:0];
                REG_SHORT_PAUSE: regs.short_pause_ms = value;
                REG_LONG_PAUSE:  regs.long_pause_ms  = value;
                default: ;
            endcase
        endfunction

        function void rise_to(logic [7:0] peak, logic [2:0] next);
            logic [8:0] sum;
            sum = {1'b0, level} + {1'b0, regs.rise_step};
            if (sum >= {1'b0, peak}) begin
                level = peak;
                phase = next;
            end else begin
                level = sum[7:0];
            end
        endfunction

        function void fall_to(logic [2:0] next, logic [31:0] now);
            if (level <= regs.fall_step) begin
                level   = '0;
                phase   = next;
                mark_ms = now;
            end else begin
                level = level - regs.fall_step;
            end
        endfunction

        function void take_command(logic [1:0] cmd, logic [31:0] now);
            logic [31:0] elapsed;
            t_led_result r;
            elapsed = now - mark_ms;
            r.drive_update = 1'b0;
            if (cmd == CMD_START) begin
                running = 1'b1;
                level   = '0;
                phase   = PH_RISE1;
                mark_ms = now;
            end else if (cmd == CMD_STOP) begin
                running = 1'b0;
                level   = '0;
                phase   = PH_RISE1;
                r.drive_update = 1'b1;
            end else if (cmd == CMD_TICK && running) begin
                case (phase)
                    PH_RISE1:  rise_to(regs.first_peak, PH_FALL1);
                    PH_FALL1:  fall_to(PH_PAUSE1, now);
                    PH_PAUSE1: if (elapsed >= {16'd0, regs.short_pause_ms}) phase = PH_RISE2;
                    PH_RISE2:  rise_to(regs.second_peak, PH_FALL2);
                    PH_FALL2:  fall_to(PH_PAUSE2, now);
                    PH_PAUSE2: if (elapsed >= {16'd0, regs.long_pause_ms}) phase = PH_RISE1;
                    default: ;
                endcase
                r.drive_update = 1'b1;
            end
            r.pwm_level = level;
            r.active    = running;
            r.phase_now = phase;
            pending.push_back(r);
        endfunction

        function void match_output(t_led_result got);
            t_led_result want;
            if (pending.size() == 0) begin
                $error("unexpected result transaction: pwm_level %0d", got.pwm_level);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.pwm_level !== want.pwm_level) begin
                $error("pwm_level: expected %0d, actual %0d", want.pwm_level, got.pwm_level);
                errors++;
            end
            if (got.drive_update !== want.drive_update) begin
                $error("drive_update: expected %0d, actual %0d", want.drive_update,
                       got.drive_update);
                errors++;
            end
            if (got.active !== want.active) begin
                $error("active: expected %0d, actual %0d", want.active, got.active);
                errors++;
            end
            if (got.phase_now !== want.phase_now) begin
                $error("phase_now: expected %0d, actual %0d", want.phase_now, got.phase_now);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    hlp_cfg_if reg_ch();
    hlp_in_if  cmd_ch();
    hlp_out_if led_ch();

    heartbeat_led_pattern uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (reg_ch.sink),
        .i_in    (cmd_ch.sink),
        .o_out   (led_ch.source)
    );

    led_pattern_tracker tracker = new();
    logic [31:0]        clock_ms;
    bit                 quiet;
    bit                 no_gaps;
    bit                 hold_request;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("Test completed with failures");
        $finish;
    end

    // result side: check each transaction, then pick ready for the next edge
    initial begin
        int stall_left;
        stall_left = 0;
        led_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && led_ch.valid && led_ch.ready) begin
                tracker.match_output(t_led_result'{led_ch.pwm_level, led_ch.drive_update,
                                                   led_ch.active, led_ch.phase_now});
            end
            if (stall_left > 0) begin
                stall_left--;
                led_ch.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                stall_left = 60;
                led_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 2);
                led_ch.ready <= 1'b0;
            end else begin
                led_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_cmd(logic [1:0] cmd, logic [31:0] now);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.now_ms  <= now;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        tracker.take_command(cmd, now);
        if (!quiet && !no_gaps && $urandom_range(0, 4) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        reg_ch.valid     <= 1'b1;
        reg_ch.reg_index <= idx;
        reg_ch.data      <= value;
        @(posedge i_clk);
        while (!reg_ch.ready) @(posedge i_clk);
        tracker.load_reg(idx, value);
    endtask

    // upper byte of the 8-bit registers carries junk
    task automatic apply_cfg(t_cfg c);
        write_reg(REG_UNUSED, 16'($urandom));
        write_reg(REG_RISE_STEP, {8'($urandom), c.rise_step});
        write_reg(REG_FALL_STEP, {8'($urandom), c.fall_step});
        write_reg(REG_FIRST_PEAK, {8'($urandom), c.first_peak});
        write_reg(REG_SECOND_PEAK, {8'($urandom), c.second_peak});
        write_reg(REG_SHORT_PAUSE, c.short_pause_ms);
        write_reg(REG_LONG_PAUSE, c.long_pause_ms);
        reg_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (tracker.pending.size() > 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_items(int count);
        logic [1:0]  cmd;
        int unsigned pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (!tracker.running && pick < 30) cmd = CMD_START;
            else if (pick < 2) cmd = CMD_START;
            else if (pick < 4) cmd = CMD_STOP;
            else if (pick < 6) cmd = CMD_IGNORED;
            else cmd = CMD_TICK;
            pick = $urandom_range(0, 99);
            if (pick < 60) clock_ms += $urandom_range(0, 40);
            else if (pick < 85) clock_ms += $urandom_range(0, 400);
            else if (pick < 96) clock_ms += $urandom_range(0, 70000);
            else clock_ms += $urandom;
            send_cmd(cmd, clock_ms);
        end
    endtask

    initial begin
        t_cfg c;
        i_rst_n          <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.command   <= CMD_TICK;
        cmd_ch.now_ms    <= '0;
        reg_ch.valid     <= 1'b0;
        reg_ch.reg_index <= REG_RISE_STEP;
        reg_ch.data      <= '0;
        quiet        = 1'b0;
        no_gaps      = 1'b0;
        hold_request = 1'b0;
        tracker.restore_defaults();
        clock_ms = $urandom;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // stopped, ignored, restart and stop at reset settings
        send_cmd(CMD_TICK, 32'd0);
        send_cmd(CMD_IGNORED, 32'hFFFF_FFFF);
        send_cmd(CMD_STOP, 32'd5);
        send_cmd(CMD_START, 32'hFFFF_FFF0);
        for (int k = 1; k <= 4; k++) send_cmd(CMD_TICK, 32'hFFFF_FFF0 + k);
        send_cmd(CMD_IGNORED, 32'd3);
        send_cmd(CMD_START, 32'd100);
        send_cmd(CMD_TICK, 32'd101);
        send_cmd(CMD_STOP, 32'd102);

        // zero first peak, zero short pause, full long pause across the wrap
        settle();
        c = '{rise_step: 8'd255, fall_step: 8'd255, first_peak: 8'd0, second_peak: 8'd1,
              short_pause_ms: 16'd0, long_pause_ms: 16'hFFFF};
        apply_cfg(c);
        send_cmd(CMD_START, 32'hFFFF_0000);
        send_cmd(CMD_TICK, 32'hFFFF_0001);
        send_cmd(CMD_TICK, 32'hFFFF_8000);
        send_cmd(CMD_TICK, 32'hFFFF_8000);
        send_cmd(CMD_TICK, 32'hFFFF_9000);
        send_cmd(CMD_TICK, 32'hFFFF_FFFF);
        send_cmd(CMD_TICK, 32'h0000_FFFD);
        send_cmd(CMD_TICK, 32'h0000_FFFE);

        // peak lowered below the level reached mid-rise
        settle();
        c = '{rise_step: 8'd200, fall_step: 8'd1, first_peak: 8'd255, second_peak: 8'd255,
              short_pause_ms: 16'hFFFF, long_pause_ms: 16'd0};
        apply_cfg(c);
        send_cmd(CMD_START, 32'd0);
        send_cmd(CMD_TICK, 32'd1);
        settle();
        c.first_peak = 8'd50;
        apply_cfg(c);
        send_cmd(CMD_TICK, 32'd2);

        for (int p = 0; p < 8; p++) begin
            settle();
            case (p)
                0: c = '{rise_step: 8'd255, fall_step: 8'd255, first_peak: 8'd255,
                         second_peak: 8'd255, short_pause_ms: 16'hFFFF,
                         long_pause_ms: 16'hFFFF};
                1: c = '{rise_step: 8'd1, fall_step: 8'd1, first_peak: 8'd1,
                         second_peak: 8'd1, short_pause_ms: 16'd0, long_pause_ms: 16'd0};
                7: begin
                    c.rise_step      = 8'($urandom_range(20, 255));
                    c.fall_step      = 8'($urandom_range(20, 255));
                    c.first_peak     = 8'($urandom_range(1, 255));
                    c.second_peak    = 8'($urandom_range(1, 255));
                    c.short_pause_ms = 16'($urandom_range(0, 60));
                    c.long_pause_ms  = 16'($urandom_range(0, 60));
                end
                default: begin
                    c.rise_step   = $urandom_range(0, 1) ? 8'($urandom_range(1, 40))
                                                         : 8'($urandom_range(1, 255));
                    c.fall_step   = $urandom_range(0, 1) ? 8'($urandom_range(1, 40))
                                                         : 8'($urandom_range(1, 255));
                    c.first_peak  = 8'($urandom_range(1, 255));
                    c.second_peak = 8'($urandom_range(1, 255));
                    c.short_pause_ms = $urandom_range(0, 1) ? 16'($urandom_range(0, 300))
                                                            : 16'($urandom);
                    c.long_pause_ms  = $urandom_range(0, 1) ? 16'($urandom_range(0, 300))
                                                            : 16'($urandom);
                end
            endcase
            if (p == 7) quiet = 1'b1;
            apply_cfg(c);
            send_cmd(CMD_START, clock_ms);
            if (p == 3) begin
                // long result stall with a steady stream of input transactions
                hold_request = 1'b1;
                no_gaps = 1'b1;
                run_items(30);
                no_gaps = 1'b0;
                settle();
            end
            run_items(180);
        end
        cmd_ch.valid <= 1'b0;
        settle();
        repeat (4) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
